// ===== sv/bgtr_pkg.sv =====
// shared types and constants of the bitmap glyph text rasterizer
package bgtr_pkg;

	localparam int APB_AW    = 5;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 88;

	// register indexes
	localparam logic [2:0] REG_DST_WIDTH    = 3'd0;
	localparam logic [2:0] REG_DST_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_SCALE        = 3'd2;
	localparam logic [2:0] REG_INK_COLOR    = 3'd3;
	localparam logic [2:0] REG_SHADOW_COLOR = 3'd4;
	localparam logic [2:0] REG_FALLBACK_ADV = 3'd5;
	localparam logic [2:0] REG_NUM_GLYPHS   = 3'd6;
	localparam logic [2:0] REG_FIRST_CHAR   = 3'd7;

	// item kinds
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	localparam logic [12:0] SURF_MAX     = 13'd4096;
	localparam logic [6:0]  RESULT_LIMIT = 7'd64;
	localparam logic [19:0] PEN_MAX      = 20'h7FFFF;

	typedef struct packed {
		logic [12:0] dst_width;
		logic [12:0] dst_height;
		logic [3:0]  scale;
		logic [31:0] ink_color;
		logic [31:0] shadow_color;
		logic [7:0]  fallback_advance;
		logic [7:0]  num_glyphs;
		logic [7:0]  first_char;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic fetch;
		logic wdth;
		logic pen;
		logic row;
		logic walk;
		logic done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_draw;
		logic go_rows;
		logic col_last;
		logic row_last;
		logic stall;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== sv/bgtr_ram.sv =====
// generic single-port-write ram with registered read
module bgtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bgtr_regs.sv =====
// apb configuration registers
module bgtr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgtr_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output bgtr_pkg::cfg_t                cfg
);

	bgtr_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dst_width        <= 13'd320;
			cfg_q.dst_height       <= 13'd200;
			cfg_q.scale            <= 4'd1;
			cfg_q.ink_color        <= 32'hFFFF_FFFF;
			cfg_q.shadow_color     <= 32'd0;
			cfg_q.fallback_advance <= 8'd8;
			cfg_q.num_glyphs       <= 8'd0;
			cfg_q.first_char       <= 8'd32;
		end else if (wr) begin
			case (idx)
				bgtr_pkg::REG_DST_WIDTH:    cfg_q.dst_width        <= pwdata[12:0];
				bgtr_pkg::REG_DST_HEIGHT:   cfg_q.dst_height       <= pwdata[12:0];
				bgtr_pkg::REG_SCALE:        cfg_q.scale            <= pwdata[3:0];
				bgtr_pkg::REG_INK_COLOR:    cfg_q.ink_color        <= pwdata;
				bgtr_pkg::REG_SHADOW_COLOR: cfg_q.shadow_color     <= pwdata;
				bgtr_pkg::REG_FALLBACK_ADV: cfg_q.fallback_advance <= pwdata[7:0];
				bgtr_pkg::REG_NUM_GLYPHS:   cfg_q.num_glyphs       <= pwdata[7:0];
				bgtr_pkg::REG_FIRST_CHAR:   cfg_q.first_char       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bgtr_pkg::REG_DST_WIDTH:    prdata = {19'd0, cfg_q.dst_width};
			bgtr_pkg::REG_DST_HEIGHT:   prdata = {19'd0, cfg_q.dst_height};
			bgtr_pkg::REG_SCALE:        prdata = {28'd0, cfg_q.scale};
			bgtr_pkg::REG_INK_COLOR:    prdata = cfg_q.ink_color;
			bgtr_pkg::REG_SHADOW_COLOR: prdata = cfg_q.shadow_color;
			bgtr_pkg::REG_FALLBACK_ADV: prdata = {24'd0, cfg_q.fallback_advance};
			bgtr_pkg::REG_NUM_GLYPHS:   prdata = {24'd0, cfg_q.num_glyphs};
			bgtr_pkg::REG_FIRST_CHAR:   prdata = {24'd0, cfg_q.first_char};
			default:                    prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/bgtr_ctrl.sv =====
// sequencer for glyph fetch, cell walk and result hand-off
module bgtr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_accept,
	input  bgtr_pkg::dp_stat_t    stat,
	output bgtr_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_WDTH  = 7'b0000100,
		ST_PEN   = 7'b0001000,
		ST_ROW   = 7'b0010000,
		ST_CELL  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && stat.is_draw) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_WDTH;
			ST_WDTH:  state_d = ST_PEN;
			ST_PEN:   state_d = stat.go_rows ? ST_ROW : ST_DONE;
			ST_ROW:   state_d = ST_CELL;
			ST_CELL: begin
				if (!stat.stall && stat.col_last) begin
					state_d = stat.row_last ? ST_DONE : ST_ROW;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.take  = (state_q == ST_IDLE);
	assign cmd.fetch = (state_q == ST_FETCH);
	assign cmd.wdth  = (state_q == ST_WDTH);
	assign cmd.pen   = (state_q == ST_PEN);
	assign cmd.row   = (state_q == ST_ROW);
	assign cmd.walk  = (state_q == ST_CELL);
	assign cmd.done  = (state_q == ST_DONE);

endmodule

// ===== sv/bgtr_dp.sv =====
// glyph stores, pen, cell clipping and result registers
module bgtr_dp #(
	parameter int MAX_GLYPHS = 128,
	parameter int GLYPH_ROWS = 8,
	parameter int GLYPH_COLS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bgtr_pkg::cfg_t                    cfg,
	input  bgtr_pkg::ctrl_cmd_t               cmd,
	output bgtr_pkg::dp_stat_t                stat,
	input  logic                              in_accept,
	input  logic [bgtr_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [0:0]                        s_tuser,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [bgtr_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic [0:0]                        m_tuser,
	output logic                              m_tlast
);

	localparam int IW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int GD = MAX_GLYPHS * GLYPH_ROWS;
	localparam int AW = (GD > 1) ? $clog2(GD) : 1;
	localparam int RW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
	localparam int CW = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
	localparam int KW = $clog2(GLYPH_COLS + 1);

	// input fields
	logic [6:0]         in_gi;
	logic [2:0]         in_gr;
	logic [7:0]         in_ink;
	logic [7:0]         in_sh;
	logic [7:0]         in_gw;
	logic [7:0]         in_cc;
	logic               in_st;
	logic signed [15:0] in_ox;
	logic signed [15:0] in_oy;

	assign in_gi  = s_tdata[6:0];
	assign in_gr  = s_tdata[9:7];
	assign in_ink = s_tdata[17:10];
	assign in_sh  = s_tdata[25:18];
	assign in_gw  = s_tdata[33:26];
	assign in_cc  = s_tdata[41:34];
	assign in_st  = s_tdata[42];
	assign in_ox  = s_tdata[58:43];
	assign in_oy  = s_tdata[74:59];

	logic is_draw;
	assign is_draw = (s_tuser[0] == bgtr_pkg::CMD_DRAW);

	// effective configuration
	logic [3:0]  sc;
	logic [12:0] sw;
	logic [12:0] sh;
	assign sc = (cfg.scale == 4'd0) ? 4'd1 : cfg.scale;
	assign sw = (cfg.dst_width > bgtr_pkg::SURF_MAX) ? bgtr_pkg::SURF_MAX : cfg.dst_width;
	assign sh = (cfg.dst_height > bgtr_pkg::SURF_MAX) ? bgtr_pkg::SURF_MAX : cfg.dst_height;

	// registers
	logic signed [19:0] pen_x_q;
	logic signed [15:0] pen_y_q;
	logic [7:0]         code_q;
	logic               found_q;
	logic [AW-1:0]      row_addr_q;
	logic [11:0]        adv_q;
	logic [KW-1:0]      cols_q;
	logic [19:0]        np_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [6:0]         n_q;
	logic [7:0]         ink_sr_q;
	logic [7:0]         sh_sr_q;
	logic signed [20:0] x0_q, x1_q;
	logic signed [17:0] y0_q, y1_q;

	logic               pend_v_q;
	logic [11:0]        pend_x_q, pend_y_q;
	logic [3:0]         pend_w_q, pend_h_q;
	logic [31:0]        pend_color_q;

	logic               out_v_q;
	logic               out_fv_q;
	logic               out_last_q;
	logic [11:0]        out_x_q, out_y_q;
	logic [3:0]         out_w_q, out_h_q;
	logic [31:0]        out_color_q;
	logic [19:0]        out_pen_q;

	// glyph lookup
	logic [8:0]    diff;
	logic          found;
	logic [IW-1:0] idx;
	logic [AW-1:0] base;

	assign diff  = {1'b0, code_q} - {1'b0, cfg.first_char};
	assign found = !diff[8] && (diff[7:0] < cfg.num_glyphs) && (32'(diff[7:0]) < MAX_GLYPHS);
	assign idx   = IW'(diff[7:0]);
	assign base  = AW'(32'(idx) * GLYPH_ROWS);

	// stores
	logic          ld_ok;
	logic [AW-1:0] row_waddr;
	logic [AW-1:0] row_raddr;
	logic          row_re;
	logic [15:0]   row_rdata;
	logic [7:0]    wid_rdata;
	logic          row_last;

	assign ld_ok     = in_accept && (s_tuser[0] == bgtr_pkg::CMD_LOAD)
	                   && (32'(in_gi) < MAX_GLYPHS) && (32'(in_gr) < GLYPH_ROWS);
	assign row_waddr = AW'(32'(in_gi) * GLYPH_ROWS + 32'(in_gr));
	assign row_last  = (row_q == RW'(GLYPH_ROWS - 1));
	assign row_raddr = cmd.fetch ? base : row_addr_q;
	assign row_re    = cmd.fetch || (cmd.row && !row_last);

	// ink in the upper byte, shadow in the lower
	bgtr_ram #(.WIDTH(16), .DEPTH(GD)) u_row_ram (
		.clk   (clk),
		.we    (ld_ok),
		.waddr (row_waddr),
		.wdata ({in_ink, in_sh}),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	bgtr_ram #(.WIDTH(8), .DEPTH(MAX_GLYPHS)) u_wid_ram (
		.clk   (clk),
		.we    (ld_ok),
		.waddr (IW'(in_gi)),
		.wdata (in_gw),
		.re    (cmd.fetch),
		.raddr (idx),
		.rdata (wid_rdata)
	);

	// advance and column count
	logic [7:0]    wsel;
	logic [KW-1:0] wcols;
	assign wsel  = found_q ? wid_rdata : cfg.fallback_advance;
	assign wcols = (32'(wid_rdata) > GLYPH_COLS) ? KW'(GLYPH_COLS) : KW'(wid_rdata);

	// saturating pen update, advance is never negative
	logic [20:0] np_sum;
	logic [19:0] np;
	assign np_sum = {pen_x_q[19], pen_x_q} + {9'd0, adv_q};
	assign np     = (np_sum[20] != np_sum[19]) ? bgtr_pkg::PEN_MAX : np_sum[19:0];

	// current cell
	logic               lit_ink, lit_sh, lit;
	logic [31:0]        color;
	logic signed [20:0] sw21, cx0, cx1, dx;
	logic signed [17:0] sh18, cy0, cy1, dy;
	logic               vis, emit, stall, out_free, col_last, cell_go;

	assign lit_ink = ink_sr_q[7];
	assign lit_sh  = !ink_sr_q[7] && (cfg.shadow_color != 32'd0) && sh_sr_q[7];
	assign lit     = lit_ink || lit_sh;
	assign color   = lit_ink ? cfg.ink_color : cfg.shadow_color;

	assign sw21 = signed'({8'd0, sw});
	assign sh18 = signed'({5'd0, sh});
	assign cx0  = x0_q[20] ? 21'sd0 : x0_q;
	assign cx1  = (x1_q > sw21) ? sw21 : x1_q;
	assign cy0  = y0_q[17] ? 18'sd0 : y0_q;
	assign cy1  = (y1_q > sh18) ? sh18 : y1_q;
	assign dx   = cx1 - cx0;
	assign dy   = cy1 - cy0;
	assign vis  = (cx1 > cx0) && (cy1 > cy0);

	assign emit     = cmd.walk && lit && vis && (n_q < bgtr_pkg::RESULT_LIMIT);
	assign out_free = !out_v_q || m_tready;
	// a new fill pushes the held one out, which needs room
	assign stall    = emit && pend_v_q && !out_free;
	assign cell_go  = cmd.walk && !stall;
	assign col_last = ((KW'(col_q) + KW'(1)) == cols_q);

	logic push_cell, push_done;
	assign push_cell = cell_go && emit && pend_v_q;
	assign push_done = cmd.done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			found_q  <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (in_accept && is_draw && in_st) begin
				pen_x_q <= 20'(in_ox);
				pen_y_q <= in_oy;
			end
			if (cmd.fetch) begin
				found_q <= found;
			end
			if (cmd.pen) begin
				row_q    <= '0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.row) begin
				col_q <= '0;
			end
			if (cell_go) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (emit) begin
					pend_v_q <= 1'b1;
					n_q      <= n_q + 7'd1;
				end
			end
			if (push_done) begin
				pend_v_q <= 1'b0;
				pen_x_q  <= np_q;
			end
			if (push_cell || push_done) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && is_draw) begin
			code_q <= in_cc;
		end
		if (cmd.fetch) begin
			row_addr_q <= base + AW'(1);
		end
		if (cmd.wdth) begin
			adv_q  <= 12'(wsel) * 12'(sc);
			cols_q <= found_q ? wcols : '0;
		end
		if (cmd.pen) begin
			np_q <= np;
			y0_q <= 18'(pen_y_q);
			y1_q <= 18'(pen_y_q) + 18'(sc);
		end
		if (cmd.row) begin
			ink_sr_q <= row_rdata[15:8];
			sh_sr_q  <= row_rdata[7:0];
			x0_q     <= 21'(pen_x_q);
			x1_q     <= 21'(pen_x_q) + 21'(sc);
			if (!row_last) begin
				row_addr_q <= row_addr_q + AW'(1);
			end
		end
		if (cell_go) begin
			ink_sr_q <= {ink_sr_q[6:0], 1'b0};
			sh_sr_q  <= {sh_sr_q[6:0], 1'b0};
			x0_q     <= x0_q + 21'(sc);
			x1_q     <= x1_q + 21'(sc);
			if (col_last) begin
				y0_q <= y0_q + 18'(sc);
				y1_q <= y1_q + 18'(sc);
			end
			if (emit) begin
				pend_x_q     <= cx0[11:0];
				pend_y_q     <= cy0[11:0];
				pend_w_q     <= dx[3:0];
				pend_h_q     <= dy[3:0];
				pend_color_q <= color;
			end
		end
		if (push_cell) begin
			out_fv_q    <= 1'b1;
			out_last_q  <= 1'b0;
			out_x_q     <= pend_x_q;
			out_y_q     <= pend_y_q;
			out_w_q     <= pend_w_q;
			out_h_q     <= pend_h_q;
			out_color_q <= pend_color_q;
			out_pen_q   <= np_q;
		end
		if (push_done) begin
			// no visible fill gives one empty closing item
			out_fv_q    <= pend_v_q;
			out_last_q  <= 1'b1;
			out_x_q     <= pend_v_q ? pend_x_q : 12'd0;
			out_y_q     <= pend_v_q ? pend_y_q : 12'd0;
			out_w_q     <= pend_v_q ? pend_w_q : 4'd0;
			out_h_q     <= pend_v_q ? pend_h_q : 4'd0;
			out_color_q <= pend_v_q ? pend_color_q : 32'd0;
			out_pen_q   <= np_q;
		end
	end

	assign stat.is_draw  = is_draw;
	assign stat.go_rows  = found_q && (cols_q != '0);
	assign stat.col_last = col_last;
	assign stat.row_last = row_last;
	assign stat.stall    = stall;
	assign stat.out_free = out_free;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, out_pen_q, out_color_q, out_h_q, out_w_q, out_y_q, out_x_q};
	assign m_tuser  = out_fv_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/bitmap_glyph_text_rasterizer.sv =====
// a load item is taken in the idle state; a draw item steps through fetch, width, pen, then per glyph row
// a row fetch and a walk of cols = min(width, GLYPH_COLS) cells, one cell per cycle plus stalls, then done
// (a missing glyph or zero cols skips the rows); one item is in work at a time
// results wait in an output register, fill items go out at most one per cycle
// reset restores register defaults and clears the pen to zero; glyph stores are not cleared
// and must be loaded before use
module bitmap_glyph_text_rasterizer #(
	parameter int MAX_GLYPHS = 128,
	parameter int GLYPH_ROWS = 8,
	parameter int GLYPH_COLS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bgtr_pkg::APB_AW-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// glyph_index, glyph_row, ink_bits, shadow_bits, glyph_width, char_code,
	// start_text, origin_x, origin_y, zero pad
	input  logic [bgtr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// command
	input  logic [0:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// rect_x, rect_y, rect_w, rect_h, fill_color, pen_after, zero pad
	output logic [bgtr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// fill_valid
	output logic [0:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);

	bgtr_pkg::cfg_t      cfg;
	bgtr_pkg::ctrl_cmd_t cmd;
	bgtr_pkg::dp_stat_t  stat;
	logic                in_accept;

	assign s_axis_tready = cmd.take;
	assign in_accept     = s_axis_tvalid && cmd.take;

	bgtr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bgtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.stat      (stat),
		.cmd       (cmd)
	);

	bgtr_dp #(
		.MAX_GLYPHS (MAX_GLYPHS),
		.GLYPH_ROWS (GLYPH_ROWS),
		.GLYPH_COLS (GLYPH_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.in_accept (in_accept),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.m_tready  (m_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.m_tlast   (m_axis_tlast)
	);

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the glyph rasterizer: glyph loads, drawn text and fill item checks
module testbench;

	localparam int GLYPHS = 128;
	localparam int ROWS = 8;
	localparam int COLS = 8;
	localparam longint PEN_HI = 524287;
	localparam longint PEN_LO = -524288;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic        lit;
		logic [11:0] x;
		logic [11:0] y;
		logic [3:0]  w;
		logic [3:0]  h;
		logic [31:0] color;
		logic [19:0] pen;
		logic        is_last;
	} fill_t;

	class fill_scoreboard;
		bgtr_pkg::cfg_t regs;
		logic [7:0] ink_rows [0:GLYPHS*ROWS-1];
		logic [7:0] shade_rows [0:GLYPHS*ROWS-1];
		logic [7:0] advance [0:GLYPHS-1];
		int pen_x;
		int pen_y;
		fill_t expected_fills[$];
		int errors;
		int loads;
		int draws;
		int fills;
		int blanks;
		int saturated;

		function new();
			regs.dst_width = 13'd320;
			regs.dst_height = 13'd200;
			regs.scale = 4'd1;
			regs.ink_color = 32'hFFFFFFFF;
			regs.shadow_color = 32'd0;
			regs.fallback_advance = 8'd8;
			regs.num_glyphs = 8'd0;
			regs.first_char = 8'd32;
			pen_x = 0;
			pen_y = 0;
			errors = 0;
			loads = 0;
			draws = 0;
			fills = 0;
			blanks = 0;
			saturated = 0;
		endfunction

		function void set_reg(input logic [2:0] idx, input logic [31:0] value);
			case (idx)
				bgtr_pkg::REG_DST_WIDTH:    regs.dst_width = value[12:0];
				bgtr_pkg::REG_DST_HEIGHT:   regs.dst_height = value[12:0];
				bgtr_pkg::REG_SCALE:        regs.scale = value[3:0];
				bgtr_pkg::REG_INK_COLOR:    regs.ink_color = value;
				bgtr_pkg::REG_SHADOW_COLOR: regs.shadow_color = value;
				bgtr_pkg::REG_FALLBACK_ADV: regs.fallback_advance = value[7:0];
				bgtr_pkg::REG_NUM_GLYPHS:   regs.num_glyphs = value[7:0];
				bgtr_pkg::REG_FIRST_CHAR:   regs.first_char = value[7:0];
				default: ;
			endcase
		endfunction

		function void note_item(input logic cmd, input logic [bgtr_pkg::S_TDATA_W-1:0] d);
			longint sc, sw, sh, x0, y0, x1, y1, adv, np;
			int idx, cols, r, c;
			logic found;
			logic [7:0] code, ib, shb;
			logic [31:0] color;
			fill_t f;
			fill_t batch[$];
			if (cmd == bgtr_pkg::CMD_LOAD) begin
				loads++;
				ink_rows[d[6:0]*ROWS + d[9:7]] = d[17:10];
				shade_rows[d[6:0]*ROWS + d[9:7]] = d[25:18];
				advance[d[6:0]] = d[33:26];
				return;
			end
			draws++;
			code = d[41:34];
			if (d[42]) begin
				pen_x = $signed(d[58:43]);
				pen_y = $signed(d[74:59]);
			end
			sc = (regs.scale == 0) ? 1 : regs.scale;
			sw = (regs.dst_width > bgtr_pkg::SURF_MAX) ? bgtr_pkg::SURF_MAX : regs.dst_width;
			sh = (regs.dst_height > bgtr_pkg::SURF_MAX) ? bgtr_pkg::SURF_MAX : regs.dst_height;
			found = 1'b0;
			idx = 0;
			if (code >= regs.first_char) begin
				idx = code - regs.first_char;
				found = (idx < regs.num_glyphs) && (idx < GLYPHS);
			end
			if (found) begin
				cols = (advance[idx] > COLS) ? COLS : advance[idx];
				for (r = 0; r < ROWS; r++) begin
					ib = ink_rows[idx*ROWS + r];
					shb = shade_rows[idx*ROWS + r];
					for (c = 0; c < cols; c++) begin
						// ink wins, shadow only when its colour is enabled
						if (ib[7-c])
							color = regs.ink_color;
						else if (regs.shadow_color != 0 && shb[7-c])
							color = regs.shadow_color;
						else
							continue;
						x0 = pen_x + c*sc;
						y0 = pen_y + r*sc;
						x1 = x0 + sc;
						y1 = y0 + sc;
						if (x0 < 0) x0 = 0;
						if (y0 < 0) y0 = 0;
						if (x1 > sw) x1 = sw;
						if (y1 > sh) y1 = sh;
						if (x1 <= x0 || y1 <= y0) continue;
						if (batch.size() >= bgtr_pkg::RESULT_LIMIT) continue;
						f.lit = 1'b1;
						f.x = x0[11:0];
						f.y = y0[11:0];
						f.w = 4'(x1 - x0);
						f.h = 4'(y1 - y0);
						f.color = color;
						f.pen = '0;
						f.is_last = 1'b0;
						batch.push_back(f);
					end
				end
				adv = advance[idx] * sc;
			end else begin
				adv = regs.fallback_advance * sc;
			end
			np = pen_x + adv;
			if (np > PEN_HI) begin
				np = PEN_HI;
				saturated++;
			end
			if (np < PEN_LO) np = PEN_LO;
			pen_x = int'(np);
			if (batch.size() == 0) begin
				f = '0;
				batch.push_back(f);
			end
			foreach (batch[k]) batch[k].pen = np[19:0];
			batch[batch.size()-1].is_last = 1'b1;
			foreach (batch[k]) expected_fills.push_back(batch[k]);
		endfunction

		function void check_fill(input logic lit, input logic [bgtr_pkg::M_TDATA_W-1:0] d,
				input logic is_last);
			fill_t got, want;
			got.lit = lit;
			got.x = d[11:0];
			got.y = d[23:12];
			got.w = d[27:24];
			got.h = d[31:28];
			got.color = d[63:32];
			got.pen = d[83:64];
			got.is_last = is_last;
			fills++;
			if (!lit) blanks++;
			if (expected_fills.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("fill item with nothing expected: x=%0d y=%0d pen=%0d",
						got.x, got.y, $signed(got.pen));
				return;
			end
			want = expected_fills.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("fill mismatch, expected lit=%b x=%0d y=%0d w=%0d h=%0d color=%h pen=%0d last=%b",
						want.lit, want.x, want.y, want.w, want.h, want.color,
						$signed(want.pen), want.is_last);
					$display("                 actual lit=%b x=%0d y=%0d w=%0d h=%0d color=%h pen=%0d last=%b",
						got.lit, got.x, got.y, got.w, got.h, got.color,
						$signed(got.pen), got.is_last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [bgtr_pkg::APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [bgtr_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [bgtr_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic m_axis_tlast;

	fill_scoreboard sb;
	logic [7:0] rows_loaded [0:GLYPHS-1];
	logic source_gaps = 1'b0;
	logic sink_stalls = 1'b0;
	int stall_cycles = 0;
	int reg_writes = 0;

	bitmap_glyph_text_rasterizer #(
		.MAX_GLYPHS(GLYPHS),
		.GLYPH_ROWS(ROWS),
		.GLYPH_COLS(COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("bitmap_glyph_text_rasterizer test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_fill(m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
	end

	// fill item sink with random back-pressure
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			hold = sink_stalls ? $urandom_range(0, 6) : 0;
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_item(input logic cmd, input logic [bgtr_pkg::S_TDATA_W-1:0] data);
		int gap;
		gap = source_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, data);
	endtask

	task automatic send_load(input logic [6:0] idx, input logic [2:0] row,
			input logic [7:0] ink, input logic [7:0] shade, input logic [7:0] wd);
		logic [bgtr_pkg::S_TDATA_W-1:0] d;
		d[31:0] = $urandom();
		d[63:32] = $urandom();
		d[79:64] = 16'($urandom());
		d[6:0] = idx;
		d[9:7] = row;
		d[17:10] = ink;
		d[25:18] = shade;
		d[33:26] = wd;
		d[79:75] = '0;
		rows_loaded[idx][row] = 1'b1;
		send_item(bgtr_pkg::CMD_LOAD, d);
	endtask

	task automatic send_draw(input logic [7:0] code, input logic start,
			input logic [15:0] ox, input logic [15:0] oy);
		logic [bgtr_pkg::S_TDATA_W-1:0] d;
		d[31:0] = $urandom();
		d[63:32] = $urandom();
		d[79:64] = 16'($urandom());
		d[41:34] = code;
		d[42] = start;
		d[58:43] = ox;
		d[74:59] = oy;
		d[79:75] = '0;
		send_item(bgtr_pkg::CMD_DRAW, d);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, value);
		reg_writes++;
	endtask

	// wait for the last fill, then let a trailing load or walk finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_fills.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_row();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic load_glyph(input logic [6:0] idx, input logic [7:0] wd);
		int r, first;
		first = $urandom_range(0, ROWS - 1);
		for (r = 0; r < ROWS; r++)
			send_load(idx, 3'((r + first) % ROWS), pick_row(), pick_row(), wd);
	endtask

	// a code that draws a fully loaded glyph or hits no glyph at all
	function automatic logic [7:0] pick_char();
		int g, code, idx;
		if ($urandom_range(0, 9) < 7) begin
			repeat (32) begin
				g = $urandom_range(0, 3) ? $urandom_range(0, 15) : $urandom_range(0, GLYPHS - 1);
				if (rows_loaded[g] == 8'hFF && g < sb.regs.num_glyphs &&
						sb.regs.first_char + g <= 255)
					return 8'(sb.regs.first_char + g);
			end
		end
		repeat (32) begin
			code = $urandom_range(0, 255);
			idx = code - sb.regs.first_char;
			if (code < sb.regs.first_char || idx >= sb.regs.num_glyphs || idx >= GLYPHS ||
					rows_loaded[idx] == 8'hFF)
				return 8'(code);
		end
		return (sb.regs.first_char != 0) ? 8'd0 : 8'd255;
	endfunction

	function automatic logic [15:0] pick_origin(input int extent);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 65535);
			1: v = -int'($urandom_range(0, 24));
			default: v = $urandom_range(0, (extent > 400) ? 400 : extent);
		endcase
		return v[15:0];
	endfunction

	function automatic logic [31:0] pick_extent();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return 32'd4096;
			2: return 32'd8191;
			default: return $urandom_range(8, 400);
		endcase
	endfunction

	initial begin
		int r;
		sb = new();
		for (r = 0; r < GLYPHS; r++) rows_loaded[r] = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// glyph 0 wide with solid and empty rows, glyph 127 with no columns
		for (r = 0; r < ROWS; r++)
			send_load(7'd0, 3'(r), (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom()),
				(r == 1) ? 8'hFF : (r == 0) ? 8'h00 : 8'($urandom()), 8'd255);
		load_glyph(7'd127, 8'd0);
		settle();
		apb_write(bgtr_pkg::REG_NUM_GLYPHS, 32'd128);
		apb_write(bgtr_pkg::REG_FIRST_CHAR, 32'd0);
		apb_write(bgtr_pkg::REG_SHADOW_COLOR, 32'h00FF00FF);
		send_draw(8'd0, 1'b1, 16'd0, 16'd0);
		send_draw(8'd127, 1'b0, 16'd0, 16'd0);
		// past the end of the store: fallback advance
		send_draw(8'd200, 1'b0, 16'd0, 16'd0);
		send_draw(8'd0, 1'b1, 16'h8000, 16'h8000);
		settle();
		// zero-width surface clips everything, the pen still moves
		apb_write(bgtr_pkg::REG_SCALE, 32'd15);
		apb_write(bgtr_pkg::REG_DST_WIDTH, 32'd0);
		apb_write(bgtr_pkg::REG_INK_COLOR, 32'd0);
		apb_write(bgtr_pkg::REG_SHADOW_COLOR, 32'hFFFFFFFF);
		send_draw(8'd0, 1'b1, 16'd0, 16'd0);
		settle();
		// oversized surface acts as 4096, scale 0 as 1
		apb_write(bgtr_pkg::REG_DST_WIDTH, 32'd8191);
		apb_write(bgtr_pkg::REG_DST_HEIGHT, 32'd8191);
		apb_write(bgtr_pkg::REG_SCALE, 32'd0);
		apb_write(bgtr_pkg::REG_FIRST_CHAR, 32'd255);
		apb_write(bgtr_pkg::REG_NUM_GLYPHS, 32'd1);
		apb_write(bgtr_pkg::REG_FALLBACK_ADV, 32'd255);
		send_draw(8'd255, 1'b1, 16'd4090, 16'd4090);
		send_draw(8'd0, 1'b0, 16'd0, 16'd0);
		send_draw(8'd255, 1'b1, 16'h7FFF, 16'h7FFF);
		settle();
		apb_write(bgtr_pkg::REG_DST_WIDTH, 32'd1);
		apb_write(bgtr_pkg::REG_DST_HEIGHT, 32'd1);
		apb_write(bgtr_pkg::REG_SCALE, 32'd15);
		send_draw(8'd255, 1'b1, 16'd0, 16'd0);

		repeat (6) begin
			settle();
			apb_write(bgtr_pkg::REG_DST_WIDTH, pick_extent());
			apb_write(bgtr_pkg::REG_DST_HEIGHT, pick_extent());
			apb_write(bgtr_pkg::REG_SCALE, $urandom_range(0, 15));
			apb_write(bgtr_pkg::REG_INK_COLOR, $urandom());
			apb_write(bgtr_pkg::REG_SHADOW_COLOR, $urandom_range(0, 1) ? $urandom() : 32'd0);
			apb_write(bgtr_pkg::REG_FALLBACK_ADV, $urandom_range(0, 255));
			apb_write(bgtr_pkg::REG_NUM_GLYPHS,
				$urandom_range(0, 1) ? $urandom_range(1, 32) : $urandom_range(0, 128));
			apb_write(bgtr_pkg::REG_FIRST_CHAR,
				$urandom_range(0, 2) ? $urandom_range(0, 64) : $urandom_range(0, 255));
			source_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 2))
				load_glyph($urandom_range(0, 3) ? 7'($urandom_range(0, 15)) : 7'($urandom()),
					$urandom_range(0, 3) ? 8'($urandom_range(1, 8)) : 8'($urandom()));
			repeat (20) begin
				// now and then a stray row rewrites part of some glyph
				if ($urandom_range(0, 15) == 0)
					send_load(7'($urandom()), 3'($urandom()), 8'($urandom()), 8'($urandom()),
						8'($urandom()));
				else
					send_draw(pick_char(), $urandom_range(0, 2) == 0,
						pick_origin(sb.regs.dst_width), pick_origin(sb.regs.dst_height));
			end
		end

		// one long line of missing glyphs drives the pen into saturation
		settle();
		apb_write(bgtr_pkg::REG_SCALE, 32'd15);
		apb_write(bgtr_pkg::REG_FALLBACK_ADV, 32'd255);
		apb_write(bgtr_pkg::REG_NUM_GLYPHS, 32'd0);
		source_gaps = 1'b0;
		sink_stalls = 1'b1;
		send_draw(pick_char(), 1'b1, 16'h7FFF, pick_origin(sb.regs.dst_height));
		repeat (134)
			send_draw(pick_char(), 1'b0, 16'($urandom()), 16'($urandom()));

		settle();
		if (sb.expected_fills.size() != 0) begin
			$display("%0d fill items never arrived", sb.expected_fills.size());
			sb.errors += sb.expected_fills.size();
		end
		$display("covered %0d glyph row loads, %0d characters, %0d register writes",
			sb.loads, sb.draws, reg_writes);
		$display("checked %0d fill items (%0d without a fill), %0d pen saturations, %0d errors",
			sb.fills, sb.blanks, sb.saturated, sb.errors);
		if (sb.errors == 0)
			$display("bitmap_glyph_text_rasterizer test passed");
		else
			$display("bitmap_glyph_text_rasterizer test failed");
		$finish;
	end

endmodule
